// ===== design/gbs_pkg.sv =====
package gbs_pkg;

    localparam int MAX_KEPT_DEF  = 256;
    localparam int MAX_BOXES_DEF = 4096;

    localparam logic [7:0] THRESHOLD_RESET = 8'd115;

    // register index of overlap_threshold
    localparam logic REG_OVERLAP_THRESHOLD = 1'b0;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
    } box_t;

    typedef struct packed {
        logic               first_of_set;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
    } in_t;

    typedef struct packed {
        logic        keep;
        logic [11:0] box_index;
        logic        store_full;
    } out_t;

    typedef struct packed {
        logic busy;
        logic suppress_valid;
        logic suppress;
    } cmp_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // 1-D intersection extent, clamped at zero
    function automatic logic [15:0] overlap_1d(
        input logic signed [15:0] a0,
        input logic [15:0]        aw,
        input logic signed [15:0] b0,
        input logic [15:0]        bw
    );
        logic signed [17:0] a0x;
        logic signed [17:0] b0x;
        logic signed [17:0] lo;
        logic signed [17:0] ea;
        logic signed [17:0] eb;
        logic signed [17:0] hi;
        logic signed [17:0] diff;
        a0x  = {{2{a0[15]}}, a0};
        b0x  = {{2{b0[15]}}, b0};
        lo   = (a0x > b0x) ? a0x : b0x;
        ea   = a0x + $signed({2'b00, aw});
        eb   = b0x + $signed({2'b00, bw});
        hi   = (ea < eb) ? ea : eb;
        diff = hi - lo;
        return (hi > lo) ? diff[15:0] : 16'd0;
    endfunction

endpackage

// ===== design/gbs_cell.sv =====
module gbs_cell (
    input  logic          clk,
    input  logic          shift,
    input  logic          load,
    input  gbs_pkg::box_t shift_in,
    input  gbs_pkg::box_t load_data,
    output gbs_pkg::box_t data
);

    gbs_pkg::box_t data_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
        else if (shift)
        begin
            data_reg <= shift_in;
        end
    end

    assign data = data_reg;

endmodule

// ===== design/gbs_compare.sv =====
module gbs_compare (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 issue,
    input  gbs_pkg::box_t        cand,
    input  logic [31:0]          area_a,
    input  logic [7:0]           threshold,
    input  gbs_pkg::box_t        kept,
    output gbs_pkg::cmp_status_t status
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [15:0] iw1_reg, ih1_reg;
    logic [31:0] area_b1_reg;
    logic [31:0] inter2_reg;
    logic [32:0] sum2_reg;
    logic [31:0] inter3_reg;
    logic [32:0] uni3_reg;
    logic [39:0] lhs4_reg;
    logic [40:0] rhs4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: extents and area of the kept box
        iw1_reg     <= gbs_pkg::overlap_1d(cand.left, cand.box_width,
                                           kept.left, kept.box_width);
        ih1_reg     <= gbs_pkg::overlap_1d(cand.top, cand.box_height,
                                           kept.top, kept.box_height);
        area_b1_reg <= kept.box_width * kept.box_height;
        // stage 2: intersection area, sum of areas
        inter2_reg  <= iw1_reg * ih1_reg;
        sum2_reg    <= {1'b0, area_a} + {1'b0, area_b1_reg};
        // stage 3: union
        inter3_reg  <= inter2_reg;
        uni3_reg    <= sum2_reg - {1'b0, inter2_reg};
        // stage 4: both sides of inter*256 > thr*union
        lhs4_reg    <= {inter3_reg, 8'd0};
        rhs4_reg    <= threshold * uni3_reg;
    end

    assign status.busy           = v1_reg | v2_reg | v3_reg | v4_reg;
    assign status.suppress_valid = v4_reg;
    assign status.suppress       = {1'b0, lhs4_reg} > rhs4_reg;

endmodule

// ===== design/greedy_box_suppression.sv =====
// Channel   | Signals                                   | Payload
// box       | box_valid, box_ready, box                 | gbs_pkg::in_t
// result    | result_valid, result_ready, result        | gbs_pkg::out_t
// config    | psel, penable, pwrite, paddr, pwdata, ... | overlap_threshold at 0x0
//
// One box at a time: with kept boxes present, the ring of kept boxes rotates once past
// the comparator, one box per cycle; the box then waits while the 4-stage comparator
// drains when the last kept boxes sit in the final ring slots.
// With an empty store, or on the first box of a set, the scan is skipped.
// Reset empties the store and the set position; the ring itself is not cleared.
// A finished result sits in the output register; a new box is taken meanwhile,
// and only the final step of the next box waits on result_ready.
module greedy_box_suppression #(
    parameter int MAX_KEPT  = gbs_pkg::MAX_KEPT_DEF,
    parameter int MAX_BOXES = gbs_pkg::MAX_BOXES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          box_valid,
    output logic          box_ready,
    input  gbs_pkg::in_t  box,
    output logic          result_valid,
    input  logic          result_ready,
    output gbs_pkg::out_t result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W = $clog2(MAX_KEPT + 1);
    localparam int POS_W = $clog2(MAX_BOXES);

    gbs_pkg::state_t      state_reg, state_next;
    logic [IDX_W-1:0]     scan_reg, scan_next;
    logic [CNT_W-1:0]     kept_count_reg, kept_count_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 suppress_reg, suppress_next;
    logic                 out_valid_reg, out_valid_next;
    gbs_pkg::out_t        out_reg, out_next;
    logic [7:0]           threshold_reg;
    gbs_pkg::box_t        cand_reg;
    logic [31:0]          area_a_reg;

    logic                 shift;
    logic                 issue;
    logic                 store_en;
    logic                 is_full;
    logic [POS_W+11:0]    pos_ext;
    gbs_pkg::cmp_status_t status;
    gbs_pkg::box_t        ring [MAX_KEPT];

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == gbs_pkg::REG_OVERLAP_THRESHOLD) ?
                    {24'd0, threshold_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= gbs_pkg::THRESHOLD_RESET;
        end
        else if (psel && penable && pwrite &&
                 paddr[2] == gbs_pkg::REG_OVERLAP_THRESHOLD)
        begin
            threshold_reg <= pwdata[7:0];
        end
    end

    // ring of kept boxes; cell 0 feeds the comparator
    for (genvar i = 0; i < MAX_KEPT; i++)
    begin : g_cell
        gbs_cell u_cell (
            .clk       (clk),
            .shift     (shift),
            .load      (store_en && kept_count_reg == CNT_W'(i)),
            .shift_in  (ring[(i + 1) % MAX_KEPT]),
            .load_data (cand_reg),
            .data      (ring[i])
        );
    end

    gbs_compare u_compare (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .cand      (cand_reg),
        .area_a    (area_a_reg),
        .threshold (threshold_reg),
        .kept      (ring[0]),
        .status    (status)
    );

    always_ff @(posedge clk)
    begin
        if (box_valid && box_ready)
        begin
            cand_reg.left       <= box.left;
            cand_reg.top        <= box.top;
            cand_reg.box_width  <= box.box_width;
            cand_reg.box_height <= box.box_height;
            area_a_reg          <= box.box_width * box.box_height;
        end
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gbs_pkg::ST_IDLE;
            scan_reg       <= '0;
            kept_count_reg <= '0;
            pos_reg        <= '0;
            suppress_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            kept_count_reg <= kept_count_next;
            pos_reg        <= pos_next;
            suppress_reg   <= suppress_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign pos_ext = {12'd0, pos_reg};
    assign is_full = kept_count_reg == CNT_W'(MAX_KEPT);

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        kept_count_next = kept_count_reg;
        pos_next        = pos_reg;
        suppress_next   = suppress_reg | (status.suppress_valid & status.suppress);
        out_valid_next  = out_valid_reg & ~result_ready;
        out_next        = out_reg;
        box_ready       = 1'b0;
        shift           = 1'b0;
        issue           = 1'b0;
        store_en        = 1'b0;
        unique case (state_reg)
            gbs_pkg::ST_IDLE:
            begin
                box_ready = 1'b1;
                if (box_valid)
                begin
                    suppress_next = 1'b0;
                    if (box.first_of_set)
                    begin
                        kept_count_next = '0;
                        pos_next        = '0;
                        state_next      = gbs_pkg::ST_DRAIN;
                    end
                    else if (kept_count_reg == '0)
                    begin
                        state_next = gbs_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        state_next = gbs_pkg::ST_SCAN;
                    end
                end
            end
            gbs_pkg::ST_SCAN:
            begin
                // full rotation so the ring comes back aligned
                shift = 1'b1;
                issue = CNT_W'(scan_reg) < kept_count_reg;
                if (scan_reg == IDX_W'(MAX_KEPT - 1))
                begin
                    scan_next  = '0;
                    state_next = gbs_pkg::ST_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            gbs_pkg::ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = gbs_pkg::ST_FINISH;
                end
            end
            gbs_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next      = 1'b1;
                    out_next.keep       = ~suppress_reg;
                    out_next.store_full = ~suppress_reg & is_full;
                    out_next.box_index  = pos_ext[11:0];
                    store_en            = ~suppress_reg & ~is_full;
                    if (store_en)
                    begin
                        kept_count_next = kept_count_reg + 1'b1;
                    end
                    pos_next   = (pos_reg == POS_W'(MAX_BOXES - 1)) ? '0 : pos_reg + 1'b1;
                    state_next = gbs_pkg::ST_IDLE;
                end
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== design/gbs_checker.sv =====
module gbs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          box_valid,
    input logic          box_ready,
    input logic          result_valid,
    input logic          result_ready,
    input gbs_pkg::out_t result
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    // transactions accepted but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (box_valid && box_ready)
        begin
            pending_next = pending_next + 1'b1;
        end
        if (result_valid && result_ready)
        begin
            pending_next = pending_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && box_ready |=> !box_ready)
        else $error("box accepted while previous still in work");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && box_ready |-> pending_reg <= 2'd1)
        else $error("more than two transactions outstanding");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 2'd0)
        else $error("result without an accepted box");

    a_full_implies_keep: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.store_full && !result.keep))
        else $error("store_full on a suppressed box");

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .box_valid    (box_valid),
    .box_ready    (box_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
